[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define XDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define XDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/xds_pa_pkg.sv]
// ----------------------------------------------------------------------------
// xds_pa_pkg
// Field widths, status codes and protocol constants of the XDS packet
// assembler.
// ----------------------------------------------------------------------------
package xds_pa_pkg;

  // Default geometry of the record stores
  localparam int CLASS_COUNT_DEF  = 8;
  localparam int TYPE_COUNT_DEF   = 32;
  localparam int RECORD_BYTES_DEF = 34;

  // Field widths
  localparam int BYTE_W   = 7;
  localparam int CLASS_W  = 3;
  localparam int STATUS_W = 3;
  localparam int LEN_W    = 6;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 32;

  typedef logic [BYTE_W-1:0]   xbyte_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes
  localparam status_t ST_ERROR      = 3'd0;
  localparam status_t ST_UNCHANGED  = 3'd1;
  localparam status_t ST_SHOWN      = 3'd2;
  localparam status_t ST_SUPPRESSED = 3'd3;
  localparam status_t ST_DROPPED    = 3'd4;

  // Control codes of the first byte
  localparam xbyte_t CODE_END = 7'h0F;

  // Time-code suppression: class 3 type 1, byte 3, bit 0x20
  localparam logic [CLASS_W-1:0] TC_CLASS = 3'd3;
  localparam xbyte_t             TC_TYPE  = 7'd1;
  localparam int                 TC_POS   = 3;
  localparam xbyte_t             TC_MASK  = 7'h20;

  // Length suppression: class 0 type 2, byte 4, low six bits above 1
  localparam logic [CLASS_W-1:0] LN_CLASS = 3'd0;
  localparam xbyte_t             LN_TYPE  = 7'd2;
  localparam int                 LN_POS   = 4;
  localparam xbyte_t             LN_MASK  = 7'h3F;

endpackage

[sv/xds_pa_ram.sv]
// ----------------------------------------------------------------------------
// xds_pa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds when no read is issued.
// ----------------------------------------------------------------------------
module xds_pa_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 8704
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/xds_packet_assembler_unit.sv]
// ----------------------------------------------------------------------------
// xds_packet_assembler_unit
// Assembles XDS packets from 7-bit caption byte pairs into an incoming record
// store, checks each closed packet, compares it with the stored record and
// copies and emits changed records byte by byte.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  in_      slave      in_tvalid/tready    tdata: first_byte, second_byte
//  out_     master     out_tvalid/tready   tdata: status..data_byte, tlast: last
//
//  An open pair or a stored data pair passes one more state (record base
//  or second byte write) before the next pair is taken; other data pairs
//  do not. A close of n bytes compares up to n-1 bytes and, if changed,
//  checks suppression and copies all n bytes; every close but a shown one
//  ends in a single result. Reset starts a clearing pass over the
//  CLASS_COUNT*TYPE_COUNT*RECORD_BYTES entries (8704 by default); no
//  transaction is taken meanwhile. A stalled output holds the sequencer
//  only with a result due; open and data pairs are taken while one waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xds_packet_assembler_unit #(
  parameter int CLASS_COUNT  = xds_pa_pkg::CLASS_COUNT_DEF,
  parameter int TYPE_COUNT   = xds_pa_pkg::TYPE_COUNT_DEF,
  parameter int RECORD_BYTES = xds_pa_pkg::RECORD_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [xds_pa_pkg::IN_W-1:0]  in_tdata,   // first_byte, second_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status, packet_class, packet_type, packet_length, byte_index, data_byte
  output logic [xds_pa_pkg::OUT_W-1:0] out_tdata,
  output logic                         out_tlast   // last
);

  import xds_pa_pkg::*;

  localparam int STORE_DEPTH = CLASS_COUNT * TYPE_COUNT * RECORD_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int REC_W       = $clog2(CLASS_COUNT * TYPE_COUNT);
  localparam int FILL_W      = $clog2(RECORD_BYTES + 1);

  // Sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_BASE   = 4'd2;
  localparam logic [3:0] S_WR2    = 4'd3;
  localparam logic [3:0] S_CMP_RD = 4'd4;
  localparam logic [3:0] S_CMP_CK = 4'd5;
  localparam logic [3:0] S_SUP_RD = 4'd6;
  localparam logic [3:0] S_SUP_CK = 4'd7;
  localparam logic [3:0] S_CP_RD  = 4'd8;
  localparam logic [3:0] S_CP_WR  = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [CLASS_W-1:0] open_class_r, open_class_nxt;
  xbyte_t             open_type_r, open_type_nxt;
  logic [FILL_W-1:0]  fill_count_r, fill_count_nxt;
  xbyte_t             running_sum_r, running_sum_nxt;
  logic [REC_W-1:0]   rec_idx_r, rec_idx_nxt;
  logic               in_tab_r, in_tab_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  xbyte_t             b2_hold_r, b2_hold_nxt;
  logic [CLASS_W-1:0] cl_class_r, cl_class_nxt;
  xbyte_t             cl_type_r, cl_type_nxt;
  logic [FILL_W-1:0]  cl_len_r, cl_len_nxt;
  logic [ADDR_W-1:0]  cl_base_r, cl_base_nxt;
  status_t            cl_status_r, cl_status_nxt;
  logic [FILL_W-1:0]  idx_r, idx_nxt;
  logic               suppress_r, suppress_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  // Record RAM ports
  logic              inc_we, inc_re, st_we, st_re;
  logic [ADDR_W-1:0] inc_waddr, inc_raddr, st_waddr, st_raddr;
  xbyte_t            inc_wdata, st_wdata, inc_rdata, st_rdata;

  xbyte_t            b1, b2, sum_nxt, sup_byte;
  logic              in_acc, out_free, is_tc, is_ln;
  logic [FILL_W:0]   fill_plus2, idx_plus1, idx_plus2, len_ext;
  logic [CLASS_W-1:0] b1_class;

  assign b1       = in_tdata[BYTE_W-1:0];
  assign b2       = in_tdata[2*BYTE_W-1:BYTE_W];
  assign b1_class = b1[CLASS_W:1];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign sum_nxt  = BYTE_W'({2'b00, running_sum_r} + {2'b00, b1} + {2'b00, b2});
  assign fill_plus2 = {1'b0, fill_count_r} + (FILL_W+1)'(2);
  assign idx_plus1  = {1'b0, idx_r} + (FILL_W+1)'(1);
  assign idx_plus2  = {1'b0, idx_r} + (FILL_W+1)'(2);
  assign len_ext    = {1'b0, cl_len_r};
  assign is_tc = (cl_class_r == TC_CLASS) && (cl_type_r == TC_TYPE);
  assign is_ln = (cl_class_r == LN_CLASS) && (cl_type_r == LN_TYPE);

  // Byte looked at by the suppression rules; outside the record it reads zero
  always_comb begin
    sup_byte = '0;
    if (is_tc && (TC_POS < RECORD_BYTES)) begin
      sup_byte = inc_rdata;
    end else if (is_ln && (LN_POS < RECORD_BYTES)) begin
      sup_byte = inc_rdata;
    end
  end

  // Sequencer and RAM access control
  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    open_class_nxt  = open_class_r;
    open_type_nxt   = open_type_r;
    fill_count_nxt  = fill_count_r;
    running_sum_nxt = running_sum_r;
    rec_idx_nxt     = rec_idx_r;
    in_tab_nxt      = in_tab_r;
    base_nxt        = base_r;
    b2_hold_nxt     = b2_hold_r;
    cl_class_nxt    = cl_class_r;
    cl_type_nxt     = cl_type_r;
    cl_len_nxt      = cl_len_r;
    cl_base_nxt     = cl_base_r;
    cl_status_nxt   = cl_status_r;
    idx_nxt         = idx_r;
    suppress_nxt    = suppress_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_last_nxt    = out_last_r;
    inc_we    = 1'b0;
    inc_waddr = base_r + ADDR_W'(fill_count_r);
    inc_wdata = b1;
    inc_re    = 1'b0;
    inc_raddr = cl_base_r + ADDR_W'(idx_r);
    st_we     = 1'b0;
    st_waddr  = cl_base_r + ADDR_W'(idx_r);
    st_wdata  = inc_rdata;
    st_re     = 1'b0;
    st_raddr  = cl_base_r + ADDR_W'(idx_r);

    case (state_r)
      // Zero both stores, one entry a cycle
      S_CLEAR: begin
        inc_we    = 1'b1;
        inc_waddr = clr_addr_r;
        inc_wdata = '0;
        st_we     = 1'b1;
        st_waddr  = clr_addr_r;
        st_wdata  = '0;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          if (b1 < CODE_END) begin
            // Open: latch class and type, restart count and sum
            open_class_nxt  = b1_class;
            open_type_nxt   = b2;
            fill_count_nxt  = '0;
            running_sum_nxt = BYTE_W'({1'b0, b1} + {1'b0, b2});
            rec_idx_nxt     = REC_W'(32'(b1_class) * TYPE_COUNT + 32'(b2));
            in_tab_nxt      = (32'(b1_class) < CLASS_COUNT) && (32'(b2) < TYPE_COUNT);
            state_nxt       = S_BASE;
          end else if (b1 != CODE_END) begin
            // Data pair: if in table and room, store first byte now, second next cycle
            running_sum_nxt = sum_nxt;
            if (fill_plus2 <= (FILL_W+1)'(RECORD_BYTES)) begin
              fill_count_nxt = FILL_W'(fill_plus2);
              if (in_tab_r) begin
                inc_we      = 1'b1;
                b2_hold_nxt = b2;
                state_nxt   = S_WR2;
              end
            end
          end else begin
            // Close: latch the packet, return open slot to class 0 type 0
            running_sum_nxt = sum_nxt;
            cl_class_nxt    = open_class_r;
            cl_type_nxt     = open_type_r;
            cl_len_nxt      = fill_count_r;
            cl_base_nxt     = base_r;
            open_class_nxt  = '0;
            open_type_nxt   = '0;
            rec_idx_nxt     = '0;
            base_nxt        = '0;
            in_tab_nxt      = 1'b1;
            idx_nxt         = '0;
            if ((fill_count_r == '0) || (sum_nxt != '0)) begin
              cl_status_nxt = ST_ERROR;
              state_nxt     = S_EMIT;
            end else if (!in_tab_r) begin
              cl_status_nxt = ST_DROPPED;
              state_nxt     = S_EMIT;
            end else if (fill_count_r < FILL_W'(2)) begin
              cl_status_nxt = ST_UNCHANGED;
              state_nxt     = S_EMIT;
            end else begin
              state_nxt = S_CMP_RD;
            end
          end
        end
      end

      // Record base of the newly opened packet
      S_BASE: begin
        base_nxt  = ADDR_W'(rec_idx_r * RECORD_BYTES);
        state_nxt = S_IDLE;
      end

      S_WR2: begin
        inc_we    = 1'b1;
        inc_waddr = base_r + ADDR_W'(fill_count_r) - ADDR_W'(1);
        inc_wdata = b2_hold_r;
        state_nxt = S_IDLE;
      end

      S_CMP_RD: begin
        inc_re    = 1'b1;
        st_re     = 1'b1;
        state_nxt = S_CMP_CK;
      end

      // Stop at the first difference, at a shared zero byte or before the last byte
      S_CMP_CK: begin
        if (st_rdata != inc_rdata) begin
          state_nxt = S_SUP_RD;
        end else if (st_rdata == '0) begin
          cl_status_nxt = ST_UNCHANGED;
          state_nxt     = S_EMIT;
        end else if (idx_plus2 < len_ext) begin
          idx_nxt   = FILL_W'(idx_plus1);
          state_nxt = S_CMP_RD;
        end else begin
          cl_status_nxt = ST_UNCHANGED;
          state_nxt     = S_EMIT;
        end
      end

      S_SUP_RD: begin
        if (is_tc && (TC_POS < RECORD_BYTES)) begin
          inc_re    = 1'b1;
          inc_raddr = cl_base_r + ADDR_W'(TC_POS);
        end else if (is_ln && (LN_POS < RECORD_BYTES)) begin
          inc_re    = 1'b1;
          inc_raddr = cl_base_r + ADDR_W'(LN_POS);
        end
        state_nxt = S_SUP_CK;
      end

      // Decide suppression and clear the stored byte past the new length
      S_SUP_CK: begin
        suppress_nxt = (is_tc && ((sup_byte & TC_MASK) == '0)) ||
                       (is_ln && ((sup_byte & LN_MASK) > BYTE_W'(1)));
        if (32'(cl_len_r) < RECORD_BYTES) begin
          st_we    = 1'b1;
          st_waddr = cl_base_r + ADDR_W'(cl_len_r);
          st_wdata = '0;
        end
        idx_nxt   = '0;
        state_nxt = S_CP_RD;
      end

      S_CP_RD: begin
        inc_re    = 1'b1;
        state_nxt = S_CP_WR;
      end

      // Copy one byte into the store, emit it when shown
      S_CP_WR: begin
        if (suppress_r || out_free) begin
          st_we = 1'b1;
          if (!suppress_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {inc_rdata, LEN_W'(idx_r), LEN_W'(cl_len_r), cl_type_r,
                             cl_class_r, ST_SHOWN};
            out_last_nxt  = (idx_plus1 == len_ext);
          end
          idx_nxt = FILL_W'(idx_plus1);
          if (idx_plus1 == len_ext) begin
            if (suppress_r) begin
              cl_status_nxt = ST_SUPPRESSED;
              state_nxt     = S_EMIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_CP_RD;
          end
        end
      end

      // Single result of a close
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {BYTE_W'(0), LEN_W'(0), LEN_W'(cl_len_r), cl_type_r,
                           cl_class_r, cl_status_r};
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      open_class_r  <= '0;
      open_type_r   <= '0;
      fill_count_r  <= '0;
      running_sum_r <= '0;
      rec_idx_r     <= '0;
      in_tab_r      <= 1'b1;
      base_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      open_class_r  <= open_class_nxt;
      open_type_r   <= open_type_nxt;
      fill_count_r  <= fill_count_nxt;
      running_sum_r <= running_sum_nxt;
      rec_idx_r     <= rec_idx_nxt;
      in_tab_r      <= in_tab_nxt;
      base_r        <= base_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    b2_hold_r   <= b2_hold_nxt;
    cl_class_r  <= cl_class_nxt;
    cl_type_r   <= cl_type_nxt;
    cl_len_r    <= cl_len_nxt;
    cl_base_r   <= cl_base_nxt;
    cl_status_r <= cl_status_nxt;
    idx_r       <= idx_nxt;
    suppress_r  <= suppress_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Incoming and stored record memories
  xds_pa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_inc_ram (
    .clk     (clk),
    .wr_en   (inc_we),
    .wr_addr (inc_waddr),
    .wr_data (inc_wdata),
    .rd_en   (inc_re),
    .rd_addr (inc_raddr),
    .rd_data (inc_rdata)
  );

  xds_pa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_st_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_en   (st_re),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Checks
  `XDS_ASSERT_IMP(a_fill_bound, 1'b1, 32'(fill_count_r) <= RECORD_BYTES, "fill count past record")
  `XDS_ASSERT_IMP(a_shown_index, out_valid_r && (out_data_r[STATUS_W-1:0] == ST_SHOWN), out_data_r[24:19] < out_data_r[18:13], "byte index not below length")
  `XDS_ASSERT_IMP(a_single_last, out_valid_r && (out_data_r[STATUS_W-1:0] != ST_SHOWN), out_last_r, "single result without last")
  `XDS_ASSERT_NXT(a_close_result, in_acc && (b1 == CODE_END), !in_tready, "close accepted without result sequence")

endmodule

[dv/xds_pa_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xds_pa_checker
// Watches both stream channels of the XDS packet assembler. It keeps its own
// copy of the packet state and of both record stores. For each accepted caption
// pair it works out the packet reports. Each report the block hands over is
// compared field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module xds_pa_checker
  import xds_pa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,    // first_byte, second_byte
  input  logic             out_tvalid,
  input  logic             out_tready,
  // status, packet_class, packet_type, packet_length, byte_index, data_byte
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             out_tlast,   // last
  output int               fail_count,
  output int               pending,
  output int               results_checked,
  output logic [4:0]       status_seen
);

  localparam int NCLS       = CLASS_COUNT_DEF;
  localparam int NTYP       = TYPE_COUNT_DEF;
  localparam int NREC       = RECORD_BYTES_DEF;
  localparam int DEPTH      = NCLS * NTYP * NREC;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    status_t            status;
    logic [CLASS_W-1:0] cls;
    xbyte_t             typ;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   idx;
    xbyte_t             data;
    logic               last;
  } xds_report_t;

  // Packet assembly state and the two record stores
  logic [CLASS_W-1:0] open_cls;
  xbyte_t             open_typ;
  int                 fill;
  xbyte_t             sum7;
  xbyte_t             incoming_mem [DEPTH];
  xbyte_t             stored_mem   [DEPTH];

  // Reports still owed by the block, oldest first
  xds_report_t        report_q [$];

  function automatic int record_base(input logic [CLASS_W-1:0] cls, input xbyte_t typ);
    return (int'(cls) * NTYP + int'(typ)) * NREC;
  endfunction

  function automatic string describe(input xds_report_t r);
    return $sformatf("status=%0d class=%0d type=%0d len=%0d idx=%0d data=%02h last=%0d",
                     r.status, r.cls, r.typ, r.len, r.idx, r.data, r.last);
  endfunction

  // Advance the packet state by one caption pair and queue its reports
  task automatic assemble_pair(input xbyte_t b1, input xbyte_t b2);
    int          base;
    int          len;
    int          i;
    logic        changed;
    logic        stop;
    logic        quiet;
    xds_report_t r;
    // open a packet
    if (b1 < CODE_END) begin
      fill     = 0;
      open_cls = b1[3:1];
      open_typ = b2;
      sum7     = b1 + b2;
      return;
    end
    sum7 = sum7 + b1 + b2;
    // data pair: store while the record has room
    if (b1 != CODE_END) begin
      if (fill + 2 <= NREC) begin
        if (int'(open_typ) < NTYP) begin
          base = record_base(open_cls, open_typ);
          incoming_mem[base + fill]     = b1;
          incoming_mem[base + fill + 1] = b2;
        end
        fill += 2;
      end
      return;
    end
    // close: report the packet and return to class 0 type 0
    r.cls    = open_cls;
    r.typ    = open_typ;
    r.len    = LEN_W'(fill);
    r.idx    = '0;
    r.data   = '0;
    r.last   = 1'b1;
    len      = fill;
    open_cls = '0;
    open_typ = '0;
    if (len == 0 || sum7 != '0) begin
      r.status = ST_ERROR;
    end else if (int'(r.typ) >= NTYP) begin
      r.status = ST_DROPPED;
    end else begin
      base    = record_base(r.cls, r.typ);
      changed = 1'b0;
      stop    = 1'b0;
      // compare all but the last byte; a zero byte shared by both records ends the compare
      for (i = 0; i + 1 < len && !stop; i++) begin
        if (stored_mem[base + i] != incoming_mem[base + i]) begin
          changed = 1'b1;
          stop    = 1'b1;
        end else if (stored_mem[base + i] == '0) begin
          stop = 1'b1;
        end
      end
      if (!changed) begin
        r.status = ST_UNCHANGED;
      end else begin
        if (len < NREC) stored_mem[base + len] = '0;
        for (i = 0; i < len; i++) stored_mem[base + i] = incoming_mem[base + i];
        quiet = 1'b0;
        if (r.cls == TC_CLASS && r.typ == TC_TYPE &&
            (incoming_mem[record_base(TC_CLASS, TC_TYPE) + TC_POS] & TC_MASK) == '0)
          quiet = 1'b1;
        if (r.cls == LN_CLASS && r.typ == LN_TYPE &&
            (incoming_mem[record_base(LN_CLASS, LN_TYPE) + LN_POS] & LN_MASK) > 7'd1)
          quiet = 1'b1;
        r.status = quiet ? ST_SUPPRESSED : ST_SHOWN;
      end
    end
    status_seen[r.status] <= 1'b1;
    if (r.status != ST_SHOWN) begin
      report_q.push_back(r);
      return;
    end
    // shown record: one report per stored byte
    for (i = 0; i < len; i++) begin
      r.idx  = LEN_W'(i);
      r.data = stored_mem[base + i];
      r.last = (i + 1 == len);
      report_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    xds_report_t got;
    xds_report_t want;
    if (!rst_n) begin
      open_cls = '0;
      open_typ = '0;
      fill     = 0;
      sum7     = '0;
      for (int k = 0; k < DEPTH; k++) begin
        incoming_mem[k] = '0;
        stored_mem[k]   = '0;
      end
      report_q.delete();
      fail_count      <= 0;
      results_checked <= 0;
      status_seen     <= '0;
      pending         <= 0;
    end else begin
      // predict on every accepted pair
      if (in_tvalid && in_tready)
        assemble_pair(in_tdata[BYTE_W-1:0], in_tdata[2*BYTE_W-1:BYTE_W]);
      // check every accepted report against the oldest one owed
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.cls    = out_tdata[5:3];
        got.typ    = out_tdata[12:6];
        got.len    = out_tdata[18:13];
        got.idx    = out_tdata[24:19];
        got.data   = out_tdata[31:25];
        got.last   = out_tlast;
        results_checked <= results_checked + 1;
        if (report_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < MAX_SHOWN)
            $display("[%0t] unexpected report: %s", $realtime, describe(got));
        end else begin
          want = report_q.pop_front();
          if (got.status != want.status || got.cls != want.cls || got.typ != want.typ ||
              got.len != want.len || got.idx != want.idx || got.data != want.data ||
              got.last != want.last) begin
            fail_count <= fail_count + 1;
            if (fail_count < MAX_SHOWN) begin
              $display("[%0t] report mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      pending <= report_q.size();
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives caption byte pairs into the XDS packet assembler: a short directed
// set of packets, then mostly well-formed random packets mixed with repeats,
// edits, bad checksums and stray pairs. Both channels idle at random; one long
// output hold-off and one full drain pause are included. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import xds_pa_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int PAIR_TARGET    = 500;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 30000;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;

  int               fail_count;
  int               pending;
  int               results_checked;
  logic [4:0]       status_seen;

  // Packet under construction, kept for repeats and edits
  xbyte_t           pkt_open;
  xbyte_t           pkt_type;
  xbyte_t           pkt_body [$];

  int               pairs_sent   = 0;
  int               packets_sent = 0;
  int               idle_cycles  = 0;
  bit               send_burst   = 1'b0;
  bit               recv_burst   = 1'b0;
  bit               hold_req     = 1'b0;

  always #CLK_HALF clk = ~clk;

  xds_packet_assembler_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  xds_pa_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .status_seen     (status_seen)
  );

  // Offer one pair after a random gap; return at the falling edge after accept
  task automatic send_pair(input xbyte_t b1, input xbyte_t b2);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, b2, b1};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  // Send open, data pairs and close; a good checksum byte zeroes the 7-bit sum
  task automatic send_packet(input bit good_sum);
    xbyte_t sum7;
    xbyte_t chk;
    sum7 = pkt_open + pkt_type + CODE_END;
    send_pair(pkt_open, pkt_type);
    for (int k = 0; k + 1 < pkt_body.size(); k += 2) begin
      sum7 = sum7 + pkt_body[k] + pkt_body[k + 1];
      send_pair(pkt_body[k], pkt_body[k + 1]);
    end
    chk = 7'd0 - sum7;
    if (!good_sum) chk = chk + 7'($urandom_range(1, 127));
    send_pair(CODE_END, chk);
    packets_sent++;
  endtask

  function automatic xbyte_t data_lead();
    // leave some bytes whose low six bits are 0 or 1
    if ($urandom_range(0, 7) == 0) return 7'h40 | 7'($urandom_range(0, 1));
    return 7'($urandom_range(16, 127));
  endfunction

  function automatic xbyte_t data_trail();
    if ($urandom_range(0, 3) == 0) return 7'h00;
    return 7'($urandom_range(0, 127));
  endfunction

  // Build a random packet, mostly in table, biased to the suppression types
  task automatic make_packet();
    int          pick;
    int          npairs;
    logic [2:0]  cls;
    logic        low;
    pick = $urandom_range(0, 99);
    cls  = 3'($urandom_range(0, 7));
    if (pick < 20) begin
      pkt_type = 7'($urandom_range(0, 3));
    end else if (pick < 30) begin
      cls      = TC_CLASS;
      pkt_type = TC_TYPE;
    end else if (pick < 40) begin
      cls      = LN_CLASS;
      pkt_type = LN_TYPE;
    end else if (pick < 88) begin
      pkt_type = 7'($urandom_range(0, 31));
    end else begin
      pkt_type = 7'($urandom_range(32, 127));
    end
    low      = (cls == 3'd7) ? 1'b0 : 1'($urandom_range(0, 1));
    pkt_open = {3'b000, cls, low};
    pick = $urandom_range(0, 99);
    if (pick < 4)       npairs = 0;
    else if (pick < 70) npairs = $urandom_range(1, 4);
    else if (pick < 92) npairs = $urandom_range(5, 16);
    else                npairs = $urandom_range(17, 20);
    pkt_body.delete();
    for (int k = 0; k < npairs; k++) begin
      pkt_body.push_back(data_lead());
      pkt_body.push_back(data_trail());
    end
  endtask

  // Reset, held from time zero and released once
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Result side: random stalls, burst stretches and one long hold-off
  initial begin
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 11);
      if (hold_req) begin
        stall    = HOLDOFF_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stall watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int  pick;
    int  k;
    bit  hold_done;
    bit  pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    wait (rst_n);
    @(negedge clk);

    // close with no packet open: empty error
    send_pair(CODE_END, 7'h00);
    // short record in class 0 type 0, shown, then sent again unchanged
    pkt_open = 7'h00;
    pkt_type = 7'h00;
    pkt_body = {7'h10, 7'h00};
    send_packet(1'b1);
    send_packet(1'b1);
    // top class and top type: beyond the table, dropped
    pkt_open = 7'h0E;
    pkt_type = 7'h7F;
    pkt_body = {7'h7F, 7'h7F};
    send_packet(1'b1);
    // time-code record with the flag bit clear: suppressed
    pkt_open = 7'h06;
    pkt_type = TC_TYPE;
    pkt_body = {7'h20, 7'h00, 7'h30, 7'h00};
    send_packet(1'b1);
    // length record with a long value: suppressed
    pkt_open = 7'h01;
    pkt_type = LN_TYPE;
    pkt_body = {7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46};
    send_packet(1'b1);
    // bad checksum
    pkt_open = 7'h03;
    pkt_type = 7'h05;
    pkt_body = {7'h55, 7'h2A};
    send_packet(1'b0);

    // Random packets with repeats, edits, bad sums and stray pairs
    while (pairs_sent < PAIR_TARGET) begin
      if (!hold_done && pairs_sent >= 150) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && pairs_sent >= 320) begin
        in_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        pause_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_pair(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      end else if (pick < 35) begin
        send_packet(1'b1);
      end else if (pick < 48 && pkt_body.size() > 0) begin
        // edit one byte of the last packet and send it again
        k = $urandom_range(0, pkt_body.size() - 1);
        pkt_body[k] = (k % 2 == 0) ? data_lead() : data_trail();
        send_packet(1'b1);
      end else begin
        make_packet();
        send_packet($urandom_range(0, 99) < 88);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then let the block settle
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d caption pairs, %0d packets, %0d reports checked, status codes seen %b.",
             pairs_sent, packets_sent, results_checked, status_seen);
    $display("Included a %0d-cycle output hold-off and a full drain pause mid-run.",
             HOLDOFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/xds_pa_pkg.sv
sv/xds_pa_ram.sv
sv/xds_packet_assembler_unit.sv
dv/xds_pa_checker.sv
dv/tb_top.sv
